### design/assert_macros.svh
// Assertion macros used by the top level of the I2C slave edge engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/i2cse_pkg.sv
// Types and constants shared by the I2C slave edge engine.
`default_nettype none
package i2cse_pkg;

    localparam int BUF_DEPTH_DEF = 16;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ADDR    = 3'd1,
        PH_ACK     = 3'd2,
        PH_DRIVE   = 3'd3,
        PH_RXDATA  = 3'd4,
        PH_RXACK   = 3'd5,
        PH_RELEASE = 3'd6,
        PH_MACK    = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        OP_SCL_RISE   = 3'd0,
        OP_SCL_FALL   = 3'd1,
        OP_SDA_RISE   = 3'd2,
        OP_SDA_FALL   = 3'd3,
        OP_HOST_WRITE = 3'd4,
        OP_HOST_READ  = 3'd5
    } op_t;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic [2:0] operation;
        logic       sda_level;
        logic       scl_level;
        logic [3:0] buffer_index;
        logic [7:0] buffer_data;
    } item_t;

    typedef struct packed {
        logic       sda_drive;
        logic       sda_drive_update;
        logic [7:0] read_data;
        logic [3:0] received_count;
        logic [2:0] phase;
    } result_t;

endpackage
`default_nettype wire

### design/i2c_slave_edge_engine.sv
// Top level of the I2C slave edge engine: input register, engine and checks.
`default_nettype none
`include "assert_macros.svh"
// I2C slave with a 7-bit address, driven one line-edge event word at a time.
// Each accepted word passes an input register and is applied to the protocol
// state and byte stores, its result word landing in an output register, so one
// word is taken every clock unless the result side holds ready low, which is the
// only limit on rate; the result register follows the input register.
// The user must write own_address through cfg_write/cfg_data only while no
// word is in flight; the block itself does not enforce this.
module i2c_slave_edge_engine #(
    parameter int BUF_DEPTH = i2cse_pkg::BUF_DEPTH_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        cfg_write,
    input  wire [6:0]  cfg_data,
    input  wire        item_valid,
    output logic       item_ready,
    input  wire [2:0]  operation,
    input  wire        sda_level,
    input  wire        scl_level,
    input  wire [3:0]  buffer_index,
    input  wire [7:0]  buffer_data,
    output logic       result_valid,
    input  wire        result_ready,
    output logic       sda_drive,
    output logic       sda_drive_update,
    output logic [7:0] read_data,
    output logic [3:0] received_count,
    output logic [2:0] phase
);
    import i2cse_pkg::*;

    item_t   item_in;
    item_t   stage_item;
    logic    stage_valid;
    logic    advance;
    result_t result;

    assign item_in.operation    = operation;
    assign item_in.sda_level    = sda_level;
    assign item_in.scl_level    = scl_level;
    assign item_in.buffer_index = buffer_index;
    assign item_in.buffer_data  = buffer_data;

    i2cse_in_reg u_in_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item_in     (item_in),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    i2cse_engine #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .stage_valid  (stage_valid),
        .stage_item   (stage_item),
        .advance      (advance),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    assign sda_drive        = result.sda_drive;
    assign sda_drive_update = result.sda_drive_update;
    assign read_data        = result.read_data;
    assign received_count   = result.received_count;
    assign phase            = result.phase;

    // The receive index always stays inside the store.
    `ASSERT_IMPL(a_rx_count_range, clk, rst_n, result_valid,
                 {1'b0, received_count} < 5'(BUF_DEPTH))
    // While receiving bytes or waiting on the master, SDA is released.
    `ASSERT_IMPL(a_sda_released, clk, rst_n,
                 result_valid && (phase == PH_RXDATA || phase == PH_RXACK || phase == PH_MACK),
                 sda_drive)
    // An accepted word is held in the input stage on the next cycle.
    `ASSERT_NEXT(a_accept_loads, clk, rst_n, item_valid && item_ready, stage_valid)

endmodule
`default_nettype wire

### design/i2cse_in_reg.sv
// Input register stage holding one accepted event word.
`default_nettype none
module i2cse_in_reg (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 item_valid,
    output logic                item_ready,
    input  wire i2cse_pkg::item_t item_in,
    input  wire                 advance,
    output logic                stage_valid,
    output i2cse_pkg::item_t    stage_item
);
    import i2cse_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign item_ready  = !valid_reg || advance;
    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

    always_comb
    begin
        if (item_valid && item_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item_in;
        end
    end

endmodule
`default_nettype wire

### design/i2cse_engine.sv
// Protocol state, byte stores and result register of the I2C slave.
`default_nettype none
module i2cse_engine #(
    parameter int BUF_DEPTH = i2cse_pkg::BUF_DEPTH_DEF
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cfg_write,
    input  wire [6:0]             cfg_data,
    input  wire                   stage_valid,
    input  wire i2cse_pkg::item_t stage_item,
    output logic                  advance,
    output logic                  result_valid,
    input  wire                   result_ready,
    output i2cse_pkg::result_t    result
);
    import i2cse_pkg::*;

    localparam int         IDX_W  = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam logic [4:0] DEPTH5 = 5'(BUF_DEPTH);

    logic [6:0] own_address_reg;

    phase_t     phase_reg, phase_next;
    logic [3:0] bit_count_reg, bit_count_next;
    logic [7:0] shift_byte_reg, shift_byte_next;
    logic [7:0] address_byte_reg, address_byte_next;
    logic       is_read_reg, is_read_next;
    logic [3:0] rx_index_reg, rx_index_next;
    logic [3:0] tx_index_reg, tx_index_next;
    logic       sda_out_reg, sda_out_next;

    logic [7:0] rx_store_reg [BUF_DEPTH];
    logic [7:0] tx_store_reg [BUF_DEPTH];

    logic       rx_wr;
    logic       tx_wr;
    logic [7:0] read_byte;

    logic       res_valid_reg;
    result_t    result_reg;

    logic       fire;
    logic [7:0] shifted;
    logic [3:0] bit_inc;
    logic [4:0] rx_sum;
    logic [4:0] tx_sum;
    logic       rx_wrap;
    logic       tx_wrap;
    logic       host_in_range;
    logic [7:0] tx_fetch;

    assign advance      = !res_valid_reg || result_ready;
    assign fire         = stage_valid && advance;
    assign result_valid = res_valid_reg;
    assign result       = result_reg;

    assign shifted       = {shift_byte_reg[6:0], stage_item.sda_level};
    assign bit_inc       = bit_count_reg + 4'd1;
    assign rx_sum        = {1'b0, rx_index_reg} + 5'd1;
    assign tx_sum        = {1'b0, tx_index_reg} + 5'd1;
    assign rx_wrap       = rx_sum >= DEPTH5;
    assign tx_wrap       = tx_sum >= DEPTH5;
    assign host_in_range = {1'b0, stage_item.buffer_index} < DEPTH5;
    assign tx_fetch      = tx_store_reg[tx_index_reg[IDX_W-1:0]];

    always_comb
    begin
        phase_next        = phase_reg;
        bit_count_next    = bit_count_reg;
        shift_byte_next   = shift_byte_reg;
        address_byte_next = address_byte_reg;
        is_read_next      = is_read_reg;
        rx_index_next     = rx_index_reg;
        tx_index_next     = tx_index_reg;
        sda_out_next      = sda_out_reg;
        rx_wr             = 1'b0;
        tx_wr             = 1'b0;
        read_byte         = 8'd0;
        if (fire)
        begin
            case (stage_item.operation)
                OP_SCL_RISE:
                begin
                    unique case (phase_reg)
                        PH_ADDR:
                        begin
                            if (bit_count_reg < BITS_PER_BYTE)
                            begin
                                bit_count_next = bit_inc;
                                if (bit_inc == BITS_PER_BYTE)
                                begin
                                    address_byte_next = shifted;
                                    shift_byte_next   = 8'd0;
                                end
                                else
                                begin
                                    shift_byte_next = shifted;
                                end
                            end
                        end
                        PH_ACK:
                        begin
                            if (is_read_reg)
                            begin
                                shift_byte_next = tx_fetch;
                                tx_index_next   = tx_wrap ? 4'd0 : tx_sum[3:0];
                            end
                            phase_next = PH_DRIVE;
                        end
                        PH_RXDATA:
                        begin
                            if (bit_inc >= BITS_PER_BYTE)
                            begin
                                rx_wr           = 1'b1;
                                rx_index_next   = rx_wrap ? 4'd0 : rx_sum[3:0];
                                phase_next      = PH_RXACK;
                                shift_byte_next = 8'd0;
                                bit_count_next  = 4'd0;
                            end
                            else
                            begin
                                shift_byte_next = shifted;
                                bit_count_next  = bit_inc;
                            end
                        end
                        PH_RXACK:
                        begin
                            phase_next = PH_RXDATA;
                        end
                        PH_MACK:
                        begin
                            if (!stage_item.sda_level)
                            begin
                                // A wrapped transmit index sends a zero byte.
                                if (tx_wrap)
                                begin
                                    tx_index_next   = 4'd0;
                                    shift_byte_next = 8'd0;
                                end
                                else
                                begin
                                    tx_index_next   = tx_sum[3:0];
                                    shift_byte_next = tx_fetch;
                                end
                                phase_next = PH_DRIVE;
                            end
                            else
                            begin
                                sda_out_next    = 1'b1;
                                tx_index_next   = 4'd0;
                                shift_byte_next = 8'd0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                OP_SCL_FALL:
                begin
                    unique case (phase_reg)
                        PH_ADDR:
                        begin
                            if (bit_count_reg == BITS_PER_BYTE)
                            begin
                                if (address_byte_reg[7:1] == own_address_reg)
                                begin
                                    is_read_next = address_byte_reg[0];
                                    sda_out_next = 1'b0;
                                    phase_next   = PH_ACK;
                                end
                                else
                                begin
                                    phase_next = PH_IDLE;
                                end
                                shift_byte_next = 8'd0;
                                bit_count_next  = 4'd0;
                            end
                        end
                        PH_DRIVE:
                        begin
                            if (is_read_reg)
                            begin
                                sda_out_next    = shift_byte_reg[7];
                                shift_byte_next = {shift_byte_reg[6:0], 1'b0};
                                if (bit_inc >= BITS_PER_BYTE)
                                begin
                                    phase_next     = PH_RELEASE;
                                    bit_count_next = 4'd0;
                                end
                                else
                                begin
                                    bit_count_next = bit_inc;
                                end
                            end
                            else
                            begin
                                sda_out_next = 1'b1;
                                phase_next   = PH_RXDATA;
                            end
                        end
                        PH_RXACK:
                        begin
                            sda_out_next = 1'b0;
                            phase_next   = PH_DRIVE;
                        end
                        PH_RELEASE:
                        begin
                            sda_out_next = 1'b1;
                            phase_next   = PH_MACK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                OP_SDA_RISE:
                begin
                    // A stop is honored in every phase.
                    if (stage_item.scl_level)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                OP_SDA_FALL:
                begin
                    if (phase_reg == PH_IDLE && stage_item.scl_level)
                    begin
                        phase_next      = PH_ADDR;
                        rx_index_next   = 4'd0;
                        tx_index_next   = 4'd0;
                        shift_byte_next = 8'd0;
                        bit_count_next  = 4'd0;
                    end
                end
                OP_HOST_WRITE:
                begin
                    tx_wr = host_in_range;
                end
                OP_HOST_READ:
                begin
                    if (host_in_range)
                    begin
                        read_byte = rx_store_reg[stage_item.buffer_index[IDX_W-1:0]];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg  <= 7'd0;
            phase_reg        <= PH_IDLE;
            bit_count_reg    <= 4'd0;
            shift_byte_reg   <= 8'd0;
            address_byte_reg <= 8'd0;
            is_read_reg      <= 1'b0;
            rx_index_reg     <= 4'd0;
            tx_index_reg     <= 4'd0;
            sda_out_reg      <= 1'b1;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                own_address_reg <= cfg_data;
            end
            phase_reg        <= phase_next;
            bit_count_reg    <= bit_count_next;
            shift_byte_reg   <= shift_byte_next;
            address_byte_reg <= address_byte_next;
            is_read_reg      <= is_read_next;
            rx_index_reg     <= rx_index_next;
            tx_index_reg     <= tx_index_next;
            sda_out_reg      <= sda_out_next;
            if (advance)
            begin
                res_valid_reg <= stage_valid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BUF_DEPTH; i++)
            begin
                rx_store_reg[i] <= 8'd0;
                tx_store_reg[i] <= 8'd0;
            end
        end
        else
        begin
            if (rx_wr)
            begin
                rx_store_reg[rx_index_reg[IDX_W-1:0]] <= shifted;
            end
            if (tx_wr)
            begin
                tx_store_reg[stage_item.buffer_index[IDX_W-1:0]] <= stage_item.buffer_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg.sda_drive        <= sda_out_next;
            result_reg.sda_drive_update <= sda_out_next != sda_out_reg;
            result_reg.read_data        <= read_byte;
            result_reg.received_count   <= rx_index_next;
            result_reg.phase            <= phase_next;
        end
    end

endmodule
`default_nettype wire
